// ===== hw/rtl/kear_pkg.sv =====
package kear_pkg;

    localparam int KEY_W   = 8;
    localparam int DELTA_W = 20;
    localparam int TIME_W  = 32;
    localparam int IVAL_W  = 24;
    localparam int LVL_DEPTH = 256;

    localparam logic [TIME_W-1:0] SAT32 = '1;
    localparam logic [TIME_W-1:0] DELAY_RESET = 32'd500000;
    localparam logic [IVAL_W-1:0] IVAL_RESET  = 24'd100000;

    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_IVAL  = 1'b1;

    typedef struct packed {
        logic capture;
        logic read;
        logic eval;
        logic div_start;
        logic div_apply;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_full;
    } t_sts;

endpackage

// ===== hw/rtl/key_edge_and_autorepeat_unit.sv =====
// Key edge and auto-repeat unit. Each request is one key sample for one frame and yields
// exactly one result with pressed, rising-edge, falling-edge and auto-repeat flags. Per key
// the unit keeps the last level, a saturating hold timer and a repeat count, all clear after
// reset. After a request is accepted the unit steps through read, evaluate and finish states,
// with a divide state before finish when the repeat count must be recomputed after the repeat
// delay has passed; there the 32-step restoring divider forms (hold time - delay) / interval.
// The finish state writes the result to the output register, and waits while a stalled result
// still holds that register. The next request is taken in the cycle after the previous one
// has been written to the output register; until then o_stall holds off new requests.
module key_edge_and_autorepeat_unit
    import kear_pkg::*;
#(
    parameter int NUM_KEYS = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [KEY_W-1:0]   i_key_index,
    input  logic               i_key_down,
    input  logic [DELTA_W-1:0] i_delta_us,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_pressed,
    output logic               o_triggered,
    output logic               o_released,
    output logic               o_repeat_fire
);

    logic [TIME_W-1:0] r_delay;
    logic [IVAL_W-1:0] r_ival;
    logic              wr_en;
    t_cmd              cmd;
    t_sts              sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
            r_ival  <= IVAL_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_DELAY: r_delay <= pwdata;
                REG_IVAL:  r_ival  <= pwdata[IVAL_W-1:0];
                default:   r_delay <= r_delay;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DELAY: prdata = r_delay;
            REG_IVAL:  prdata = {{(32 - IVAL_W){1'b0}}, r_ival};
            default:   prdata = '0;
        endcase
    end

    kear_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    kear_dp #(
        .NUM_KEYS (NUM_KEYS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_delay       (r_delay),
        .i_ival        (r_ival),
        .i_key_index   (i_key_index),
        .i_key_down    (i_key_down),
        .i_delta_us    (i_delta_us),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_pressed     (o_pressed),
        .o_triggered   (o_triggered),
        .o_released    (o_released),
        .o_repeat_fire (o_repeat_fire)
    );

endmodule

// ===== hw/rtl/kear_div.sv =====
module kear_div
    import kear_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [IVAL_W-1:0] i_divisor,
    output logic              o_done,
    output logic [TIME_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(TIME_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_q;
    logic [IVAL_W-1:0] r_rem;
    logic [IVAL_W-1:0] r_div;
    logic [IVAL_W:0]   rem_sh;
    logic [IVAL_W:0]   rem_sub;
    logic              ge;

    assign rem_sh  = {r_rem, r_q[TIME_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign ge      = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= (i_divisor == '0) ? IVAL_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[TIME_W-2:0], ge};
            r_rem <= ge ? rem_sub[IVAL_W-1:0] : rem_sh[IVAL_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/kear_dp.sv =====
module kear_dp
    import kear_pkg::*;
#(
    parameter int NUM_KEYS = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [TIME_W-1:0]  i_delay,
    input  logic [IVAL_W-1:0]  i_ival,
    input  logic [KEY_W-1:0]   i_key_index,
    input  logic               i_key_down,
    input  logic [DELTA_W-1:0] i_delta_us,
    input  logic               i_stall,
    output logic               o_valid,
    output logic               o_pressed,
    output logic               o_triggered,
    output logic               o_released,
    output logic               o_repeat_fire
);

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [2*TIME_W-1:0] r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_tvld;
    logic [LVL_DEPTH-1:0] r_prev_lvl;

    logic [KEY_W-1:0]   r_key;
    logic               r_down;
    logic [DELTA_W-1:0] r_delta;
    logic [2*TIME_W-1:0] r_rdata;
    logic               r_rvld;
    logic               r_prev;
    logic [TIME_W-1:0]  r_timer;
    logic [TIME_W-1:0]  r_count;
    logic               r_fire;
    logic               r_out_valid;
    logic               r_out_pressed;
    logic               r_out_trig;
    logic               r_out_rel;
    logic               r_out_fire;

    logic [AW-1:0]     addr;
    logic              in_range;
    logic [TIME_W-1:0] t_old;
    logic [TIME_W-1:0] c_old;
    logic [TIME_W:0]   t_sum;
    logic [TIME_W-1:0] t_new;
    logic [TIME_W-1:0] c_new;
    logic              n_fire;
    logic [TIME_W-1:0] n_count;
    logic              need_div;
    logic [TIME_W-1:0] dividend;
    logic              div_done;
    logic [TIME_W-1:0] quot;
    logic [TIME_W-1:0] target;

    assign addr     = r_key[AW-1:0];
    assign in_range = {1'b0, r_key} < (KEY_W + 1)'(NUM_KEYS);
    assign t_old    = r_rvld ? r_rdata[2*TIME_W-1:TIME_W] : '0;
    assign c_old    = r_rvld ? r_rdata[TIME_W-1:0] : '0;
    assign t_sum    = {1'b0, t_old} + (TIME_W + 1)'(r_delta);
    assign t_new    = !r_down ? '0 : (t_sum[TIME_W] ? SAT32 : t_sum[TIME_W-1:0]);
    assign c_new    = r_down ? c_old : '0;
    assign dividend = t_new - i_delay;
    assign target   = (&quot) ? quot : quot + 1'b1;

    always_comb begin
        n_fire   = 1'b0;
        n_count  = c_new;
        need_div = 1'b0;
        if (in_range && t_new != '0) begin
            if (c_new == '0) begin
                n_fire  = 1'b1;
                n_count = TIME_W'(1);
            end else if (t_new >= i_delay) begin
                need_div = 1'b1;
            end
        end
    end

    kear_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (i_ival),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key   <= i_key_index;
            r_down  <= i_key_down;
            r_delta <= i_delta_us;
        end
        if (i_cmd.read) begin
            r_prev <= r_prev_lvl[r_key];
            if (in_range) begin
                r_rdata <= r_mem[addr];
                r_rvld  <= r_tvld[addr];
            end else begin
                r_rvld <= 1'b0;
            end
        end
        if (i_cmd.eval) begin
            r_timer <= t_new;
            r_count <= n_count;
            r_fire  <= n_fire;
        end
        if (i_cmd.div_apply && target > r_count) begin
            r_count <= target;
            r_fire  <= 1'b1;
        end
        if (i_cmd.finish && in_range) begin
            r_mem[addr] <= {r_timer, r_count};
        end
        if (i_cmd.finish) begin
            r_out_pressed <= r_down;
            r_out_trig    <= !r_prev && r_down;
            r_out_rel     <= r_prev && !r_down;
            r_out_fire    <= r_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld      <= '0;
            r_prev_lvl  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_prev_lvl[r_key] <= r_down;
                if (in_range) begin
                    r_tvld[addr] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.need_div = need_div;
    assign o_sts.div_done = div_done;
    assign o_sts.out_full = r_out_valid && i_stall;

    assign o_valid       = r_out_valid;
    assign o_pressed     = r_out_pressed;
    assign o_triggered   = r_out_trig;
    assign o_released    = r_out_rel;
    assign o_repeat_fire = r_out_fire;

endmodule

// ===== hw/rtl/kear_ctrl.sv =====
module kear_ctrl
    import kear_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_apply = 1'b1;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_sts.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != ST_IDLE;

endmodule
